// File: rtl/xor_checked_frame_parser_macros.svh
// Assertion macros shared by the frame parser checker.
`ifndef XOR_CHECKED_FRAME_PARSER_MACROS_SVH
`define XOR_CHECKED_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define XCFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define XCFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/xcfp_pkg.sv
// Shared constants, types and structs of the XOR-checked frame parser.
`timescale 1ns / 1ps
package xcfp_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int LEN_W = 6;
  localparam int DATA_W = 8;

  localparam logic [DATA_W-1:0] HDR_BYTE = 8'hAA;
  localparam logic [DATA_W-1:0] TRL_BYTE = 8'hBB;
  localparam logic [LEN_W-1:0] MAXPAY_RESET = 6'd20;
  localparam logic [DATA_W-1:0] LIMIT_CAP = DATA_W'(PAYLOAD_DEPTH);

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_LEN_ERR   = 2'd1,
    ST_FRAME_ERR = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_CMD     = 7'b0000100,
    PH_PAY     = 7'b0001000,
    PH_CHK     = 7'b0010000,
    PH_TRL_OK  = 7'b0100000,
    PH_TRL_BAD = 7'b1000000
  } phase_t;

  // One result request from the parser to the output pipeline.
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [DATA_W-1:0] command;
    logic [LEN_W-1:0]  payload_length;
    logic              data_valid;
    logic              last;
  } req_t;

  // Payload store control.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
  } ram_ctl_t;

endpackage

// File: rtl/xcfp_if.sv
// Channel interfaces: received bytes, configuration writes and results.
`timescale 1ns / 1ps
interface xcfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] max_payload;
  modport source (output valid, output max_payload, input ready);
  modport sink (input valid, input max_payload, output ready);
endinterface

interface xcfp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] command;
  logic [5:0] payload_length;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       last;
  modport source (output valid, output status, output command, output payload_length,
                  output data_byte, output data_valid, output last, input ready);
  modport sink (input valid, input status, input command, input payload_length,
                input data_byte, input data_valid, input last, output ready);
endinterface

// File: rtl/xcfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module xcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/xcfp_parser.sv
// Frame state machine and payload replay sequencer.
`timescale 1ns / 1ps
module xcfp_parser (
  input  logic                            clk,
  input  logic                            rst,
  xcfp_rx_if.sink                         rx,
  input  logic [xcfp_pkg::LEN_W-1:0]      max_payload,
  output xcfp_pkg::req_t                  req,
  input  logic                            req_ready,
  output xcfp_pkg::ram_ctl_t              ram
);

  xcfp_pkg::phase_t                  phase, phase_next;
  logic [xcfp_pkg::LEN_W-1:0]        frame_length, frame_length_next;
  logic [xcfp_pkg::DATA_W-1:0]       command_reg, command_reg_next;
  logic [xcfp_pkg::DATA_W-1:0]       xor_acc, xor_acc_next;
  logic [xcfp_pkg::LEN_W-1:0]        byte_index, byte_index_next;
  logic                              rep_busy, rep_busy_next;
  logic [xcfp_pkg::LEN_W-1:0]        rep_idx, rep_idx_next;

  logic                              accept;
  logic [xcfp_pkg::DATA_W-1:0]       b;
  logic [xcfp_pkg::DATA_W-1:0]       limit;
  logic                              rep_last;
  logic [xcfp_pkg::LEN_W-1:0]        bi_inc;

  assign rx.ready = !rep_busy && req_ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign limit    = ({2'b00, max_payload} > xcfp_pkg::LIMIT_CAP) ? xcfp_pkg::LIMIT_CAP
                                                                  : {2'b00, max_payload};
  assign rep_last = (xcfp_pkg::LEN_W'(rep_idx + 1'b1) == frame_length);
  assign bi_inc   = xcfp_pkg::LEN_W'(byte_index + 1'b1);

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    command_reg_next  = command_reg;
    xor_acc_next      = xor_acc;
    byte_index_next   = byte_index;
    rep_busy_next     = rep_busy;
    rep_idx_next      = rep_idx;
    req               = '0;
    ram               = '0;
    ram.wr_addr       = xcfp_pkg::ADDR_W'(byte_index);
    ram.wr_data       = b;
    ram.rd_addr       = xcfp_pkg::ADDR_W'(rep_idx);

    if (rep_busy) begin
      // replay stored payload, one result per request slot
      req.valid          = 1'b1;
      req.status         = xcfp_pkg::ST_GOOD;
      req.command        = command_reg;
      req.payload_length = frame_length;
      req.data_valid     = 1'b1;
      req.last           = rep_last;
      ram.rd_en          = req_ready;
      if (req_ready) begin
        rep_idx_next = xcfp_pkg::LEN_W'(rep_idx + 1'b1);
        if (rep_last) begin
          rep_busy_next = 1'b0;
        end
      end
    end else if (accept) begin
      unique case (phase)
        xcfp_pkg::PH_LEN: begin
          if (b > limit) begin
            req.valid  = 1'b1;
            req.status = xcfp_pkg::ST_LEN_ERR;
            req.last   = 1'b1;
            phase_next = xcfp_pkg::PH_HUNT;
          end else begin
            frame_length_next = b[xcfp_pkg::LEN_W-1:0];
            xor_acc_next      = b;
            phase_next        = xcfp_pkg::PH_CMD;
          end
        end
        xcfp_pkg::PH_CMD: begin
          command_reg_next = b;
          xor_acc_next     = xor_acc ^ b;
          byte_index_next  = '0;
          phase_next       = (frame_length != '0) ? xcfp_pkg::PH_PAY : xcfp_pkg::PH_CHK;
        end
        xcfp_pkg::PH_PAY: begin
          ram.wr_en       = (int'(byte_index) < xcfp_pkg::PAYLOAD_DEPTH);
          xor_acc_next    = xor_acc ^ b;
          byte_index_next = bi_inc;
          if (bi_inc >= frame_length) begin
            phase_next = xcfp_pkg::PH_CHK;
          end
        end
        xcfp_pkg::PH_CHK: begin
          phase_next = (b == xor_acc) ? xcfp_pkg::PH_TRL_OK : xcfp_pkg::PH_TRL_BAD;
        end
        xcfp_pkg::PH_TRL_OK, xcfp_pkg::PH_TRL_BAD: begin
          if (phase == xcfp_pkg::PH_TRL_BAD || b != xcfp_pkg::TRL_BYTE) begin
            req.valid          = 1'b1;
            req.status         = xcfp_pkg::ST_FRAME_ERR;
            req.command        = command_reg;
            req.payload_length = frame_length;
            req.last           = 1'b1;
          end else if (frame_length == '0) begin
            req.valid   = 1'b1;
            req.status  = xcfp_pkg::ST_GOOD;
            req.command = command_reg;
            req.last    = 1'b1;
          end else begin
            rep_busy_next = 1'b1;
            rep_idx_next  = '0;
          end
          phase_next = xcfp_pkg::PH_HUNT;
        end
        default: begin
          phase_next = (b == xcfp_pkg::HDR_BYTE) ? xcfp_pkg::PH_LEN : xcfp_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= xcfp_pkg::PH_HUNT;
      frame_length <= '0;
      command_reg  <= '0;
      xor_acc      <= '0;
      byte_index   <= '0;
      rep_busy     <= 1'b0;
      rep_idx      <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      command_reg  <= command_reg_next;
      xor_acc      <= xor_acc_next;
      byte_index   <= byte_index_next;
      rep_busy     <= rep_busy_next;
      rep_idx      <= rep_idx_next;
    end
  end

endmodule

// File: rtl/xcfp_out.sv
// Two-stage result pipeline: RAM read stage and output register.
`timescale 1ns / 1ps
module xcfp_out (
  input  logic                         clk,
  input  logic                         rst,
  input  xcfp_pkg::req_t               req,
  output logic                         req_ready,
  input  logic [xcfp_pkg::DATA_W-1:0]  ram_data,
  xcfp_res_if.source                   res
);

  xcfp_pkg::req_t               s1;
  logic                         s1_valid;
  xcfp_pkg::req_t               outr;
  logic                         out_valid;
  logic [xcfp_pkg::DATA_W-1:0]  out_data;
  logic                         s2_load;

  assign s2_load   = s1_valid && (!out_valid || res.ready);
  assign req_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid <= req.valid;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      s1 <= req;
    end
    if (s2_load) begin
      outr     <= s1;
      out_data <= s1.data_valid ? ram_data : '0;
    end
  end

  assign res.valid          = out_valid;
  assign res.status         = outr.status;
  assign res.command        = outr.command;
  assign res.payload_length = outr.payload_length;
  assign res.data_byte      = out_data;
  assign res.data_valid     = outr.data_valid;
  assign res.last           = outr.last;

endmodule

// File: rtl/xor_checked_frame_parser.sv
// Top level of the XOR-checked serial frame parser.
// Usage:
//   rx  : one received byte per request (rx_byte). Frames are 0xAA, length,
//         command, payload, XOR checksum of length/command/payload, 0xBB.
//   res : results with status, command, payload_length, data_byte,
//         data_valid, last. A good frame yields one result per payload byte
//         (or one result if empty); a long length or a bad checksum/trailer
//         yields one error result. last marks the final result.
//   cfg : writes max_payload; always ready, takes effect on the next byte.
// Throughput: one rx byte per cycle while no replay runs and res is taken.
// After a good trailer, rx is held off while the payload store is replayed,
// one result per cycle while res is taken, at the rate of the single store
// read port. An error or empty-frame result is registered in the read stage
// and then the output register; the first payload result of a good frame
// takes the same path once the replay has started after its trailer.
// Reset: parser hunts for 0xAA, max_payload = 20, no result pending. The
// payload store is not cleared; only entries written in the frame are read.
// Receiver stall: one result waits in the output register and one in the
// read stage; once both are held, rx and the replay stop until res is taken.
`timescale 1ns / 1ps
module xor_checked_frame_parser (
  input  logic        clk,
  input  logic        rst,
  xcfp_rx_if.sink     rx,
  xcfp_cfg_if.sink    cfg,
  xcfp_res_if.source  res
);

  logic [xcfp_pkg::LEN_W-1:0]   max_payload;
  xcfp_pkg::req_t               req;
  logic                         req_ready;
  xcfp_pkg::ram_ctl_t           ram;
  logic [xcfp_pkg::DATA_W-1:0]  ram_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= xcfp_pkg::MAXPAY_RESET;
    end else if (cfg.valid) begin
      max_payload <= cfg.max_payload;
    end
  end

  xcfp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .max_payload (max_payload),
    .req         (req),
    .req_ready   (req_ready),
    .ram         (ram)
  );

  xcfp_ram #(
    .WIDTH (xcfp_pkg::DATA_W),
    .DEPTH (xcfp_pkg::PAYLOAD_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (ram.wr_data),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (ram_data)
  );

  xcfp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_ready (req_ready),
    .ram_data  (ram_data),
    .res       (res)
  );

endmodule

// File: rtl/xcfp_checker.sv
// Port-level assertion checker for the frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "xor_checked_frame_parser_macros.svh"
module xcfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_status,
  input logic [5:0] res_payload_length,
  input logic       res_data_valid,
  input logic       res_last
);

  `XCFP_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
  `XCFP_ASSERT_IMP(a_data_good, res_valid && res_data_valid, res_status == xcfp_pkg::ST_GOOD, "payload byte on error result")
  `XCFP_ASSERT_IMP(a_err_last, res_valid && res_status != xcfp_pkg::ST_GOOD, res_last && !res_data_valid, "error result not single and last")
  `XCFP_ASSERT_IMP(a_rst_empty, $past(rst), !res_valid, "result present right after reset")
  `XCFP_ASSERT_IMP(a_len_bound, res_valid && res_data_valid, res_payload_length != 6'd0 && int'(res_payload_length) <= xcfp_pkg::PAYLOAD_DEPTH, "payload length out of range")

endmodule

bind xor_checked_frame_parser xcfp_checker u_xcfp_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_status         (res.status),
  .res_payload_length (res.payload_length),
  .res_data_valid     (res.data_valid),
  .res_last           (res.last)
);

// File: tb/xcfp_frame_checker.sv
// Frame parser checker: predicts results from accepted bytes and compares them.
`timescale 1ns / 1ps
module xcfp_frame_checker
  import xcfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  xcfp_rx_if   rx,
  xcfp_cfg_if  cfg,
  xcfp_res_if  res,
  output int   mismatch_count,
  output int   pending_results,
  output int   results_checked,
  output int   good_frames,
  output int   rejected_frames
);

  typedef struct {
    status_t          status;
    logic [7:0]       command;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_byte;
    logic             data_valid;
    logic             last;
  } frame_result_t;

  frame_result_t expected_results[$];

  logic [5:0]       max_payload;
  phase_t           phase;
  logic [LEN_W-1:0] frame_len;
  logic [7:0]       frame_cmd;
  logic [7:0]       running_xor;
  logic [5:0]       byte_idx;
  logic [7:0]       payload_mem [PAYLOAD_DEPTH];
  int               errs;
  int               n_results;
  int               n_good;
  int               n_rejected;

  function automatic void queue_result(input status_t st, input logic [7:0] cmd,
                                       input logic [LEN_W-1:0] plen,
                                       input logic [7:0] data, input logic dv,
                                       input logic lst);
    frame_result_t r;
    r.status         = st;
    r.command        = cmd;
    r.payload_length = plen;
    r.data_byte      = data;
    r.data_valid     = dv;
    r.last           = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int limit;
    int i;
    limit = (max_payload < PAYLOAD_DEPTH) ? int'(max_payload) : PAYLOAD_DEPTH;
    case (phase)
      PH_LEN: begin
        if (b > limit) begin
          queue_result(ST_LEN_ERR, 8'h00, '0, 8'h00, 1'b0, 1'b1);
          phase = PH_HUNT;
        end else begin
          frame_len   = b[LEN_W-1:0];
          running_xor = b;
          phase       = PH_CMD;
        end
      end
      PH_CMD: begin
        frame_cmd   = b;
        running_xor = running_xor ^ b;
        byte_idx    = '0;
        phase       = (frame_len != 0) ? PH_PAY : PH_CHK;
      end
      PH_PAY: begin
        if (byte_idx < PAYLOAD_DEPTH) payload_mem[byte_idx] = b;
        running_xor = running_xor ^ b;
        byte_idx    = byte_idx + 1'b1;
        if (byte_idx >= frame_len) phase = PH_CHK;
      end
      PH_CHK: begin
        phase = (b == running_xor) ? PH_TRL_OK : PH_TRL_BAD;
      end
      PH_TRL_OK, PH_TRL_BAD: begin
        if (phase == PH_TRL_BAD || b != TRL_BYTE) begin
          queue_result(ST_FRAME_ERR, frame_cmd, frame_len, 8'h00, 1'b0, 1'b1);
        end else if (frame_len == 0) begin
          queue_result(ST_GOOD, frame_cmd, '0, 8'h00, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < frame_len && i < PAYLOAD_DEPTH; i++)
            queue_result(ST_GOOD, frame_cmd, frame_len, payload_mem[i], 1'b1,
                         (i + 1 == frame_len));
        end
        phase = PH_HUNT;
      end
      default: begin
        phase = (b == HDR_BYTE) ? PH_LEN : PH_HUNT;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (rst) begin
      max_payload = MAXPAY_RESET;
      phase       = PH_HUNT;
      frame_len   = '0;
      frame_cmd   = '0;
      running_xor = '0;
      byte_idx    = '0;
      expected_results.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d command 0x%02h data 0x%02h",
                 res.status, res.command, res.data_byte);
          errs++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 8'(want.status), 8'(res.status));
          check_field("command", want.command, res.command);
          check_field("payload_length", 8'(want.payload_length), 8'(res.payload_length));
          check_field("data_byte", want.data_byte, res.data_byte);
          check_field("data_valid", 8'(want.data_valid), 8'(res.data_valid));
          check_field("last", 8'(want.last), 8'(res.last));
          n_results++;
          if (want.last) begin
            if (want.status == ST_GOOD) n_good++;
            else n_rejected++;
          end
        end
      end
      if (cfg.valid && cfg.ready) max_payload = cfg.max_payload;
      if (rx.valid && rx.ready) parse_byte(rx.rx_byte);
    end
    pending_results <= expected_results.size();
    mismatch_count  <= errs;
    results_checked <= n_results;
    good_frames     <= n_good;
    rejected_frames <= n_rejected;
  end

  initial begin
    errs       = 0;
    n_results  = 0;
    n_good     = 0;
    n_rejected = 0;
  end

endmodule

// File: tb/testbench.sv
// Testbench top: drives frames and register writes into the frame parser.
`timescale 1ns / 1ps
module testbench;
  import xcfp_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_STALL   = 300;
  localparam int PHASE_BYTES  = 22;

  typedef enum {FRAME_OK, FRAME_BAD_SUM, FRAME_BAD_TRAILER} frame_kind_t;

  logic clk;
  logic rst;

  xcfp_rx_if  rx_ch ();
  xcfp_cfg_if cfg_ch ();
  xcfp_res_if res_ch ();

  int         mismatch_count;
  int         pending_results;
  int         results_checked;
  int         good_frames;
  int         rejected_frames;
  int         bytes_sent;
  int         settings_used;
  int         cycle_count;
  logic [5:0] cur_max;
  bit         sender_calm;
  bit         receiver_calm;
  bit         hold_req;

  xor_checked_frame_parser dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .cfg (cfg_ch),
    .res (res_ch)
  );

  xcfp_frame_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .rx              (rx_ch),
    .cfg             (cfg_ch),
    .res             (res_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .good_frames     (good_frames),
    .rejected_frames (rejected_frames)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int cur_limit();
    return (cur_max < PAYLOAD_DEPTH) ? int'(cur_max) : PAYLOAD_DEPTH;
  endfunction

  function automatic logic [7:0] pick_length();
    int lim;
    lim = cur_limit();
    if ($urandom_range(0, 7) == 0) return 8'(lim);
    return 8'($urandom_range(0, (lim < 6) ? lim : 6));
  endfunction

  // one byte per request
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                            input frame_kind_t kind);
    logic [7:0] xor_sum;
    logic [7:0] d;
    int         i;
    xor_sum = len ^ cmd;
    if ($urandom_range(0, 3) == 0) sender_calm = !sender_calm;
    send_byte(HDR_BYTE);
    send_byte(len);
    if (len > cur_limit()) return;
    send_byte(cmd);
    for (i = 0; i < len; i++) begin
      d = 8'($urandom);
      xor_sum = xor_sum ^ d;
      send_byte(d);
    end
    if (kind == FRAME_BAD_SUM) send_byte(xor_sum ^ 8'($urandom_range(1, 255)));
    else send_byte(xor_sum);
    if (kind == FRAME_BAD_TRAILER) begin
      d = 8'($urandom_range(0, 254));
      if (d >= TRL_BYTE) d++;
      send_byte(d);
    end else begin
      send_byte(TRL_BYTE);
    end
  endtask

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [5:0] value);
    wait_idle();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.max_payload <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_max = value;
    settings_used++;
  endtask

  task automatic random_phase(input int budget);
    int         phase_end;
    int         pick;
    int         n;
    logic [7:0] len;
    phase_end = bytes_sent + budget;
    while (bytes_sent < phase_end) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(pick_length(), 8'($urandom), FRAME_OK);
      end else if (pick < 75) begin
        send_frame(pick_length(), 8'($urandom), FRAME_BAD_SUM);
      end else if (pick < 83) begin
        send_frame(pick_length(), 8'($urandom), FRAME_BAD_TRAILER);
      end else if (pick < 92) begin
        len = 8'($urandom_range(cur_limit() + 1, 255));
        send_frame(len, 8'($urandom), FRAME_OK);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // result side: random backpressure plus one long hold-off
  initial begin : receiver
    int gap;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        if ($urandom_range(0, 15) == 0) receiver_calm = !receiver_calm;
        gap = receiver_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, pending_results);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] directed_bytes [28];
    int         i;
    directed_bytes = '{
      8'h00, 8'hFF,                                // noise while hunting
      8'hAA, 8'h00, 8'hFF, 8'hFF, 8'hBB,           // empty good frame
      8'hAA, 8'h15,                                // length above limit
      8'hAA, 8'h01, 8'h00, 8'h5A, 8'h00, 8'hBB,    // bad checksum
      8'hAA, 8'h02, 8'h80, 8'h00, 8'hFF, 8'h7D, 8'h00, // bad trailer
      8'hAA, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hBB     // one-byte good frame
    };
    bytes_sent    = 0;
    settings_used = 0;
    cur_max       = MAXPAY_RESET;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    hold_req      = 1'b0;
    rst                <= 1'b1;
    rx_ch.valid        <= 1'b0;
    rx_ch.rx_byte      <= 8'h00;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.max_payload <= 6'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 28; i++) send_byte(directed_bytes[i]);
    send_frame(8'(cur_limit()), 8'h5C, FRAME_OK);

    // widest payload, and results held back until the input stalls
    write_max_payload(6'd32);
    hold_req = 1'b1;
    send_frame(8'd32, 8'h3C, FRAME_OK);
    send_frame(8'd8, 8'hC3, FRAME_OK);
    send_frame(8'd33, 8'h11, FRAME_OK);
    random_phase(PHASE_BYTES);

    write_max_payload(6'd0);
    random_phase(PHASE_BYTES);

    write_max_payload(6'd63);
    send_frame(8'd33, 8'h22, FRAME_OK);
    random_phase(PHASE_BYTES);

    write_max_payload(6'($urandom_range(0, 63)));
    random_phase(PHASE_BYTES);

    write_max_payload(MAXPAY_RESET);
    random_phase(PHASE_BYTES);

    wait_idle();
    $display("run covered %0d bytes and %0d results over %0d register settings",
             bytes_sent, results_checked, settings_used);
    $display("frames: %0d good, %0d rejected", good_frames, rejected_frames);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/xcfp_pkg.sv
rtl/xcfp_if.sv
rtl/xcfp_ram.sv
rtl/xcfp_parser.sv
rtl/xcfp_out.sv
rtl/xor_checked_frame_parser.sv
rtl/xcfp_checker.sv
tb/xcfp_frame_checker.sv
tb/testbench.sv
